[sv/lbds_pkg.sv]
// Shared types, constants and helper functions for the bouncing-dot scanner.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package lbds_pkg;

  // Pixel store geometry
  localparam int MAX_PIXELS = 256;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int LEN_W      = $clog2(MAX_PIXELS + 1);
  localparam int CMP_W      = (LEN_W > 9) ? LEN_W : 9;
  localparam int IX_W       = (LEN_W > 8) ? LEN_W : 8;
  localparam int POS_X_W    = (ADDR_W > 8) ? ADDR_W : 8;

  // Tail and arithmetic widths
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int TAIL_W = 6;
  localparam int TP_W   = ((ADDR_W > TAIL_W) ? ADDR_W : TAIL_W) + 2;

  localparam logic [CH_W-1:0]   FADE_SCALE   = 8'd215;
  localparam logic [CH_W-1:0]   FULL_SCALE   = 8'd255;
  localparam logic [TAIL_W-1:0] TAIL_DEFAULT = 6'd20;
  localparam logic [9:0]        SKIP_STEP    = 10'd254;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_LEN   = 3'd5;

  localparam logic [CH_W-1:0] RST_COLOR_RED   = 8'd255;
  localparam logic [CH_W-1:0] RST_COLOR_GREEN = 8'd0;
  localparam logic [CH_W-1:0] RST_COLOR_BLUE  = 8'd0;
  localparam logic [CH_W-1:0] RST_SPEED       = 8'd128;
  localparam logic [CH_W-1:0] RST_INTENSITY   = 8'd80;
  localparam logic [8:0]      RST_STRIP_LEN   = 9'd256;

  // Operation codes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic              busy;
    logic [CH_W-1:0]   quot;
    logic [TAIL_W-1:0] rem;
  } div_res_t;

  function automatic logic [CH_W-1:0] scale_channel(input logic [CH_W-1:0] c,
                                                    input logic [CH_W-1:0] s);
    logic [15:0] p;
    p = {8'b0, c} * ({8'b0, s} + 16'd1);
    return p[15:8];
  endfunction

  function automatic logic [PIX_W-1:0] scale_pixel(input logic [PIX_W-1:0] px,
                                                   input logic [CH_W-1:0]  s);
    return {scale_channel(px[23:16], s), scale_channel(px[15:8], s),
            scale_channel(px[7:0], s)};
  endfunction

  // frames per step: 4 - (3*(speed-1))/254, quotient found by compares
  function automatic logic [2:0] frame_skip(input logic [CH_W-1:0] spd);
    logic [9:0] x;
    logic [2:0] q;
    x = ({2'b00, spd} - 10'd1) * 10'd3;
    if (x >= 10'(3 * SKIP_STEP))      q = 3'd3;
    else if (x >= 10'(2 * SKIP_STEP)) q = 3'd2;
    else if (x >= SKIP_STEP)          q = 3'd1;
    else                              q = 3'd0;
    return (spd == 8'd0) ? 3'd4 : (3'd4 - q);
  endfunction

endpackage

`default_nettype wire

[sv/lbds_in_if.sv]
// Input channel of the bouncing-dot scanner: valid/ready plus the item fields.
// Depends on nothing.
`default_nettype none

interface lbds_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       first_frame;
  logic [7:0] pixel_index;

  modport source (output valid, output operation, output first_frame,
                  output pixel_index, input ready);
  modport sink   (input valid, input operation, input first_frame,
                  input pixel_index, output ready);
endinterface

`default_nettype wire

[sv/lbds_out_if.sv]
// Result channel of the bouncing-dot scanner: valid/ready plus the result fields.
// Depends on nothing.
`default_nettype none

interface lbds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic [7:0] dot_position;
  logic       moving_backward;

  modport source (output valid, output pixel_red, output pixel_green,
                  output pixel_blue, output dot_position, output moving_backward,
                  input ready);
  modport sink   (input valid, input pixel_red, input pixel_green,
                  input pixel_blue, input dot_position, input moving_backward,
                  output ready);
endinterface

`default_nettype wire

[sv/lbds_pixel_ram.sv]
// Pixel store: one write port and one registered read port, 24-bit RGB entries.
// Depends on lbds_pkg.
`default_nettype none

module lbds_pixel_ram (
  input  wire logic                       clk_i,
  input  wire lbds_pkg::mem_wr_t          wr_i,
  input  wire logic                       rd_en_i,
  input  wire logic [lbds_pkg::ADDR_W-1:0] rd_addr_i,
  output logic      [lbds_pkg::PIX_W-1:0]  rd_data_o
);

  logic [lbds_pkg::PIX_W-1:0] mem [lbds_pkg::MAX_PIXELS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[sv/lbds_div.sv]
// Serial restoring divider: 255 / tail length, one quotient bit per cycle.
// Depends on lbds_pkg.
`default_nettype none

module lbds_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lbds_pkg::TAIL_W-1:0] divisor_i,
  output lbds_pkg::div_res_t               res_o
);

  localparam int TW = lbds_pkg::TAIL_W;
  localparam int CW = lbds_pkg::CH_W;

  logic [CW-1:0]         acc_q, acc_d;
  logic [TW-1:0]         rem_q, rem_d;
  logic [TW-1:0]         dvs_q, dvs_d;
  logic [$clog2(CW)-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;

  logic [TW:0] sh;
  logic        ge;

  always_comb begin
    sh     = {rem_q, acc_q[CW-1]};
    ge     = (sh >= {1'b0, dvs_q});
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = lbds_pkg::FULL_SCALE;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // dividend bits shift out the top, quotient bits shift in at the bottom
      acc_d = {acc_q[CW-2:0], ge};
      rem_d = ge ? TW'(sh - {1'b0, dvs_q}) : sh[TW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(CW))'(CW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign res_o.busy = busy_q;
  assign res_o.quot = acc_q;
  assign res_o.rem  = rem_q;

endmodule

`default_nettype wire

[sv/led_bouncing_dot_scanner.sv]
// Bouncing-dot scanner top level: sequencer around the pixel store and divider.
// Depends on lbds_pkg, lbds_in_if, lbds_out_if, lbds_pixel_ram and lbds_div.
//
// After reset the block clears every entry of the pixel store and takes no
// item meanwhile; configuration writes are taken at any time. A read item
// passes through accept (which starts the memory read), result load and
// result push. A frame item uses the tail length (intensity/4, or 20 when
// intensity is zero): the fade walks the strip in use one pixel per cycle
// through the single read/write port pair, then the dot, the tail pixels one
// by one and the position update follow. The tail waits until the serial
// divider is done, which holds back short strips. An empty strip goes
// straight to its result. One item is in work at a time; the result
// register lets the next item be accepted while the previous result waits.
`default_nettype none

module led_bouncing_dot_scanner (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lbds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lbds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lbds_in_if.sink                             in_i,
  lbds_out_if.source                          out_o
);

  localparam int AW  = lbds_pkg::ADDR_W;
  localparam int LW  = lbds_pkg::LEN_W;
  localparam int CPW = lbds_pkg::CMP_W;
  localparam int IXW = lbds_pkg::IX_W;
  localparam int PXW = lbds_pkg::POS_X_W;
  localparam int TW  = lbds_pkg::TAIL_W;
  localparam int TPW = lbds_pkg::TP_W;
  localparam int PW  = lbds_pkg::PIX_W;
  localparam int CW  = lbds_pkg::CH_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FADE,
    ST_DOT,
    ST_TWAIT,
    ST_TAIL,
    ST_STEP,
    ST_PUSH
  } state_e;

  // configuration registers
  logic [CW-1:0] col_r_q, col_g_q, col_b_q, speed_q, inten_q;
  logic [8:0]    strip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_r_q <= lbds_pkg::RST_COLOR_RED;
      col_g_q <= lbds_pkg::RST_COLOR_GREEN;
      col_b_q <= lbds_pkg::RST_COLOR_BLUE;
      speed_q <= lbds_pkg::RST_SPEED;
      inten_q <= lbds_pkg::RST_INTENSITY;
      strip_q <= lbds_pkg::RST_STRIP_LEN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbds_pkg::REG_COLOR_RED:   col_r_q <= cfg_data_i[7:0];
        lbds_pkg::REG_COLOR_GREEN: col_g_q <= cfg_data_i[7:0];
        lbds_pkg::REG_COLOR_BLUE:  col_b_q <= cfg_data_i[7:0];
        lbds_pkg::REG_SPEED:       speed_q <= cfg_data_i[7:0];
        lbds_pkg::REG_INTENSITY:   inten_q <= cfg_data_i[7:0];
        lbds_pkg::REG_STRIP_LEN:   strip_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // derived settings
  logic [LW-1:0] len_w;
  logic [TW-1:0] tail_w;
  logic [PW-1:0] color_w;
  logic [2:0]    skip_w;

  assign len_w   = (CPW'(strip_q) > CPW'(lbds_pkg::MAX_PIXELS)) ?
                   LW'(lbds_pkg::MAX_PIXELS) : LW'(strip_q);
  assign tail_w  = (inten_q == '0) ? lbds_pkg::TAIL_DEFAULT : inten_q[7:2];
  assign color_w = {col_r_q, col_g_q, col_b_q};
  assign skip_w  = lbds_pkg::frame_skip(speed_q);

  // state
  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          back_q, back_d;
  logic [2:0]    fc_q, fc_d;
  logic [LW-1:0] k_q, k_d;
  logic          fade_v_q, fade_v_d;
  logic [AW-1:0] fade_addr_q, fade_addr_d;
  logic [TW-1:0] i_q, i_d;
  logic [CW-1:0] q_q, q_d;
  logic [TW-1:0] r_q, r_d;
  logic          oob_q, oob_d;
  logic [PW-1:0] res_px_q, res_px_d;
  logic          out_valid_q, out_valid_d;
  logic [PW-1:0] out_px_q, out_px_d;
  logic [CW-1:0] out_pos_q, out_pos_d;
  logic          out_back_q, out_back_d;

  // memory and divider hookup
  lbds_pkg::mem_wr_t  wr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [PW-1:0]      rd_data;
  logic               div_start;
  lbds_pkg::div_res_t div_res;
  logic               in_ready;

  lbds_pixel_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lbds_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (tail_w),
    .res_o     (div_res)
  );

  logic [PXW-1:0] pos_x;
  assign pos_x = PXW'(pos_q);

  always_comb begin
    logic signed [TPW-1:0] len_s;
    logic signed [TPW-1:0] pos_s;
    logic signed [TPW-1:0] tp;
    logic signed [TPW-1:0] p;
    logic        [TW:0]    r_sum;
    logic                  carry;
    logic        [CW:0]    q_sum;
    logic        [2:0]     fc_inc;

    len_s  = $signed(TPW'(len_w));
    pos_s  = $signed(TPW'(pos_q));
    tp     = back_q ? (pos_s + $signed(TPW'(i_q))) : (pos_s - $signed(TPW'(i_q)));
    r_sum  = {1'b0, r_q} + {1'b0, div_res.rem};
    carry  = (r_sum >= {1'b0, tail_w});
    q_sum  = {1'b0, q_q} + {1'b0, div_res.quot} + {{CW{1'b0}}, carry};
    fc_inc = fc_q + 3'd1;
    p      = pos_s;

    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    back_d      = back_q;
    fc_d        = fc_q;
    k_d         = k_q;
    fade_v_d    = 1'b0;
    fade_addr_d = fade_addr_q;
    i_d         = i_q;
    q_d         = q_q;
    r_d         = r_q;
    oob_d       = oob_q;
    res_px_d    = res_px_q;
    out_valid_d = out_valid_q;
    out_px_d    = out_px_q;
    out_pos_d   = out_pos_q;
    out_back_d  = out_back_q;
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    div_start   = 1'b0;
    wr          = '0;

    // fade write-back, in the cycle after its read
    if (fade_v_q) begin
      wr.en   = 1'b1;
      wr.addr = fade_addr_q;
      wr.data = lbds_pkg::scale_pixel(rd_data, lbds_pkg::FADE_SCALE);
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_q;
        wr.data = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(lbds_pkg::MAX_PIXELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.operation == lbds_pkg::OP_READ) begin
            rd_en   = 1'b1;
            rd_addr = AW'(in_i.pixel_index);
            oob_d   = !(IXW'(in_i.pixel_index) < IXW'(lbds_pkg::MAX_PIXELS));
            state_d = ST_READ;
          end else if (len_w == '0) begin
            // empty strip: nothing changes, result still goes out
            res_px_d = '0;
            state_d  = ST_PUSH;
          end else begin
            if (in_i.first_frame) begin
              pos_d  = '0;
              back_d = 1'b0;
              fc_d   = '0;
            end
            k_d       = '0;
            div_start = 1'b1;
            state_d   = ST_FADE;
          end
        end
      end
      ST_READ: begin
        res_px_d = oob_q ? '0 : rd_data;
        state_d  = ST_PUSH;
      end
      ST_FADE: begin
        if (k_q < len_w) begin
          rd_en       = 1'b1;
          rd_addr     = k_q[AW-1:0];
          fade_v_d    = 1'b1;
          fade_addr_d = k_q[AW-1:0];
          k_d         = k_q + 1'b1;
        end else begin
          state_d = ST_DOT;
        end
      end
      ST_DOT: begin
        // dot is skipped when the strip shrank below the position
        if (LW'(pos_q) < len_w) begin
          wr.en   = 1'b1;
          wr.addr = pos_q;
          wr.data = color_w;
        end
        state_d = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (!div_res.busy) begin
          q_d     = div_res.quot;
          r_d     = div_res.rem;
          i_d     = TW'(1);
          state_d = (tail_w == '0) ? ST_STEP : ST_TAIL;
        end
      end
      ST_TAIL: begin
        // q_q = i*255/tail kept incrementally from 255/tail and 255%tail
        if (tp >= 0 && tp < len_s) begin
          wr.en   = 1'b1;
          wr.addr = tp[AW-1:0];
          wr.data = lbds_pkg::scale_pixel(color_w, lbds_pkg::FULL_SCALE - q_q);
        end
        r_d = carry ? TW'(r_sum - {1'b0, tail_w}) : r_sum[TW-1:0];
        q_d = q_sum[CW-1:0];
        if (i_q == tail_w) begin
          state_d = ST_STEP;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_STEP: begin
        if (fc_inc >= skip_w) begin
          fc_d = '0;
          p    = back_q ? (pos_s - $signed(TPW'(1))) : (pos_s + $signed(TPW'(1)));
        end else begin
          fc_d = fc_inc;
        end
        if (p >= len_s || p < 0) begin
          back_d = !back_q;
          if (p < 0) begin
            p = '0;
          end else if (p > len_s - $signed(TPW'(1))) begin
            p = len_s - $signed(TPW'(1));
          end
        end
        pos_d    = p[AW-1:0];
        res_px_d = '0;
        state_d  = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_px_d    = res_px_q;
          out_pos_d   = pos_x[7:0];
          out_back_d  = back_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pos_q       <= '0;
      back_q      <= 1'b0;
      fc_q        <= '0;
      k_q         <= '0;
      fade_v_q    <= 1'b0;
      fade_addr_q <= '0;
      i_q         <= '0;
      q_q         <= '0;
      r_q         <= '0;
      oob_q       <= 1'b0;
      res_px_q    <= '0;
      out_valid_q <= 1'b0;
      out_px_q    <= '0;
      out_pos_q   <= '0;
      out_back_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pos_q       <= pos_d;
      back_q      <= back_d;
      fc_q        <= fc_d;
      k_q         <= k_d;
      fade_v_q    <= fade_v_d;
      fade_addr_q <= fade_addr_d;
      i_q         <= i_d;
      q_q         <= q_d;
      r_q         <= r_d;
      oob_q       <= oob_d;
      res_px_q    <= res_px_d;
      out_valid_q <= out_valid_d;
      out_px_q    <= out_px_d;
      out_pos_q   <= out_pos_d;
      out_back_q  <= out_back_d;
    end
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.pixel_red       = out_px_q[23:16];
  assign out_o.pixel_green     = out_px_q[15:8];
  assign out_o.pixel_blue      = out_px_q[7:0];
  assign out_o.dot_position    = out_pos_q;
  assign out_o.moving_backward = out_back_q;

  // fade write-back stays inside the strip in use
  a_fade_in_strip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_v_q |-> (LW'(fade_addr_q) < len_w))
    else $error("fade write outside strip");

  // no store writes while waiting for an item
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr.en)
    else $error("pixel store written while idle");

  // position update always lands inside the strip
  a_pos_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |=> (LW'(pos_q) < len_w))
    else $error("dot position outside strip after step");

  // tail painting uses a finished quotient
  a_tail_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAIL) |-> !div_res.busy)
    else $error("tail painted while divider busy");

endmodule

`default_nettype wire
